// File: src/cce_pkg.sv
// Shared types and constants for the C comment extractor.
package cce_pkg;

   // Scan modes of the byte classifier.
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SLASH  = 3'd1,
      MODE_LINE   = 3'd2,
      MODE_BLOCK  = 3'd3,
      MODE_SQUOTE = 3'd4,
      MODE_DQUOTE = 3'd5
   } scan_mode_type;

   // Kinds of reported comment.
   typedef logic [1:0] comment_kind_type;

   localparam comment_kind_type KIND_LINE         = 2'd0;
   localparam comment_kind_type KIND_BLOCK_ONE    = 2'd1;
   localparam comment_kind_type KIND_BLOCK_MULTI  = 2'd2;
   localparam comment_kind_type KIND_UNTERMINATED = 2'd3;

   // Width of the reported offsets and line numbers.
   localparam int OUT_BITS = 32;

   // Characters that steer the scan.
   localparam logic [7:0] CHAR_END       = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

endpackage

// File: src/cce_if.sv
// Valid/ready channel interfaces for source bytes and comment reports.
interface cce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface cce_rsp_if;
   import cce_pkg::*;

   logic                  valid;
   logic                  ready;
   comment_kind_type      comment_kind;
   logic [OUT_BITS-1:0]   start_offset;
   logic [OUT_BITS-1:0]   end_offset;
   logic [OUT_BITS-1:0]   start_line;

   modport source (output valid, output comment_kind, output start_offset,
                   output end_offset, output start_line, input ready);
   modport sink   (input valid, input comment_kind, input start_offset,
                   input end_offset, input start_line, output ready);
endinterface

// File: src/c_comment_extractor.sv
// Top level of the C comment extractor: byte scanner and result register.
//
//   channel    direction  payload                                        
//   req_chan   in         text_byte (8 bits, zero ends the text)         
//   rsp_chan   out        comment_kind, start_offset, end_offset,        
//                         start_line (2/32/32/32 bits)                   
//
// One byte is taken per cycle while req_chan.ready is high; the scan state and the counters are updated
// in the cycle of the transaction, and any comment it closes appears on
// rsp_chan in the next cycle.
// The only limit on throughput is the single result register: a byte is
// taken whenever that register is empty or is being emptied in the same cycle.
// Reset is synchronous and active high; it clears the scan state, the
// counters and the result valid flag, and holds req_chan.ready low.
module c_comment_extractor #(
   parameter int COUNT_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   cce_req_if.sink    req_chan,
   cce_rsp_if.source  rsp_chan
);
   import cce_pkg::*;

   // Counters are COUNT_BITS wide and wrap; the outputs carry their low
   // bits, zero-extended when the counters are narrower than the outputs.
   function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[OUT_BITS-1:0];
   endfunction

   // Scan state.
   scan_mode_type          mode_ff,       mode_in;
   logic                   escape_ff,     escape_in;
   logic                   star_ff,       star_in;
   logic                   newline_ff,    newline_in;
   logic [COUNT_BITS-1:0]  line_ff,       line_in;
   logic [COUNT_BITS-1:0]  pos_ff,        pos_in;
   logic [COUNT_BITS-1:0]  body_start_ff, body_start_in;
   logic [COUNT_BITS-1:0]  body_line_ff,  body_line_in;

   // Result register.
   logic                   rsp_valid_ff,  rsp_valid_in;
   comment_kind_type       kind_ff,       kind_in;
   logic [OUT_BITS-1:0]    start_ff,      start_in;
   logic [OUT_BITS-1:0]    end_ff,        end_in;
   logic [OUT_BITS-1:0]    sline_ff,      sline_in;

   logic                   accept;
   logic                   emit;
   comment_kind_type       emit_kind;
   logic [COUNT_BITS-1:0]  emit_end;
   logic [7:0]             c;

   assign c = req_chan.text_byte;

   // A byte may enter whenever the result register is free or is drained now.
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // Next scan mode.
   always_comb begin
      mode_in = mode_ff;
      if (c == CHAR_END) begin
         mode_in = MODE_NORMAL;
      end else begin
         case (mode_ff)
            MODE_LINE: begin
               if (c == CHAR_NEWLINE) mode_in = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (c == CHAR_SLASH && star_ff) mode_in = MODE_NORMAL;
            end
            MODE_SQUOTE, MODE_DQUOTE: begin
               if (!escape_ff && c != CHAR_BACKSLASH &&
                   ((mode_ff == MODE_SQUOTE && c == CHAR_SQUOTE) ||
                    (mode_ff == MODE_DQUOTE && c == CHAR_DQUOTE)))
                  mode_in = MODE_NORMAL;
            end
            default: begin
               // Normal text, and a slash that is not followed by an opener
               // falls back to handling this byte as normal text.
               if (mode_ff == MODE_SLASH && c == CHAR_SLASH)
                  mode_in = MODE_LINE;
               else if (mode_ff == MODE_SLASH && c == CHAR_STAR)
                  mode_in = MODE_BLOCK;
               else if (c == CHAR_SLASH)
                  mode_in = MODE_SLASH;
               else if (c == CHAR_SQUOTE)
                  mode_in = MODE_SQUOTE;
               else if (c == CHAR_DQUOTE)
                  mode_in = MODE_DQUOTE;
               else
                  mode_in = MODE_NORMAL;
            end
         endcase
      end
   end

   // Counters, body bookkeeping and the reported comment.
   always_comb begin
      escape_in     = escape_ff;
      star_in       = star_ff;
      newline_in    = newline_ff;
      line_in       = line_ff;
      pos_in        = pos_ff + COUNT_BITS'(1);
      body_start_in = body_start_ff;
      body_line_in  = body_line_ff;
      emit          = 1'b0;
      emit_kind     = KIND_LINE;
      emit_end      = pos_ff - COUNT_BITS'(1);

      if (c == CHAR_END) begin
         // End of text: report an open comment or literal, then clear all.
         emit          = (mode_ff == MODE_LINE)   || (mode_ff == MODE_BLOCK) ||
                         (mode_ff == MODE_SQUOTE) || (mode_ff == MODE_DQUOTE);
         emit_kind     = KIND_UNTERMINATED;
         escape_in     = 1'b0;
         star_in       = 1'b0;
         newline_in    = 1'b0;
         line_in       = '0;
         pos_in        = '0;
         body_start_in = '0;
         body_line_in  = '0;
      end else begin
         case (mode_ff)
            MODE_LINE: begin
               if (c == CHAR_NEWLINE) begin
                  emit      = 1'b1;
                  emit_kind = KIND_LINE;
                  line_in   = line_ff + COUNT_BITS'(1);
               end
            end
            MODE_BLOCK: begin
               if (c == CHAR_SLASH && star_ff) begin
                  emit       = 1'b1;
                  emit_kind  = newline_ff ? KIND_BLOCK_MULTI : KIND_BLOCK_ONE;
                  emit_end   = pos_ff - COUNT_BITS'(2);
                  star_in    = 1'b0;
                  newline_in = 1'b0;
               end else begin
                  if (c == CHAR_NEWLINE) begin
                     line_in    = line_ff + COUNT_BITS'(1);
                     newline_in = 1'b1;
                  end
                  star_in = (c == CHAR_STAR);
               end
            end
            MODE_SQUOTE, MODE_DQUOTE: begin
               // An escaped newline still counts as a line.
               if (c == CHAR_NEWLINE) line_in = line_ff + COUNT_BITS'(1);
               if (escape_ff)
                  escape_in = 1'b0;
               else if (c == CHAR_BACKSLASH)
                  escape_in = 1'b1;
            end
            default: begin
               if ((mode_ff == MODE_SLASH &&
                    (c == CHAR_SLASH || c == CHAR_STAR)) ||
                   (mode_ff != MODE_SLASH &&
                    (c == CHAR_SQUOTE || c == CHAR_DQUOTE)) ||
                   (mode_ff == MODE_SLASH &&
                    (c == CHAR_SQUOTE || c == CHAR_DQUOTE))) begin
                  // A comment or literal body starts after this byte.
                  body_start_in = pos_ff + COUNT_BITS'(1);
                  body_line_in  = line_ff;
                  star_in       = 1'b0;
                  newline_in    = 1'b0;
                  escape_in     = 1'b0;
               end else if (c == CHAR_NEWLINE) begin
                  line_in = line_ff + COUNT_BITS'(1);
               end
            end
         endcase
      end

      // Result register: load on a new report, drop when taken.
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      kind_in      = kind_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      sline_in     = sline_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = emit_kind;
         start_in     = to_out(body_start_ff);
         end_in       = to_out(emit_end);
         sline_in     = to_out(body_line_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         escape_ff     <= 1'b0;
         star_ff       <= 1'b0;
         newline_ff    <= 1'b0;
         line_ff       <= '0;
         pos_ff        <= '0;
         body_start_ff <= '0;
         body_line_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            escape_ff     <= escape_in;
            star_ff       <= star_in;
            newline_ff    <= newline_in;
            line_ff       <= line_in;
            pos_ff        <= pos_in;
            body_start_ff <= body_start_in;
            body_line_ff  <= body_line_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the result register needs no reset.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      sline_ff <= sline_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.comment_kind = kind_ff;
   assign rsp_chan.start_offset = start_ff;
   assign rsp_chan.end_offset   = end_ff;
   assign rsp_chan.start_line   = sline_ff;

endmodule

// File: src/cce_checker.sv
// Port-level checks of the C comment extractor and their binding.
module cce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_text_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_comment_kind
);
   import cce_pkg::*;

   // A report that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction withdrawn before it was taken");

   // No report is offered in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A fresh report always follows an accepted byte.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without an input transaction");

   // The block takes bytes whenever its result register is empty.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

   // Only the end-of-text byte gives an unterminated report, and it gives
   // no other kind.
   a_unterminated: assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && req_ready) && rsp_valid |->
         ((rsp_comment_kind == KIND_UNTERMINATED) == ($past(req_text_byte) == CHAR_END)))
      else $error("unterminated report does not match end of text");

endmodule

bind c_comment_extractor cce_checker u_cce_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_text_byte    (req_chan.text_byte),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_comment_kind (rsp_chan.comment_kind)
);

// File: bench/c_comment_extractor_checker.sv
// Checker for the C comment extractor: predicts the comment reports and compares them.
module c_comment_extractor_checker (
   input  logic clock,
   input  logic reset,
   cce_req_if   req_chan,
   cce_rsp_if   rsp_chan,
   output int   error_count,
   output int   reports_pending,
   output int   reports_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import cce_pkg::*;

   typedef struct packed {
      comment_kind_type    comment_kind;
      logic [OUT_BITS-1:0] start_offset;
      logic [OUT_BITS-1:0] end_offset;
      logic [OUT_BITS-1:0] start_line;
   } comment_report_type;

   // Scanner state of the prediction.
   scan_mode_type       mode;
   logic                escaped;
   logic                star_pending;
   logic                multi_line;
   logic [OUT_BITS-1:0] line_no;
   logic [OUT_BITS-1:0] position;
   logic [OUT_BITS-1:0] body_pos;
   logic [OUT_BITS-1:0] body_line_no;

   comment_report_type  expected_reports [$];
   int                  mismatches;
   int                  checked;

   function automatic void clear_scan();
      mode         = MODE_NORMAL;
      escaped      = 1'b0;
      star_pending = 1'b0;
      multi_line   = 1'b0;
      line_no      = '0;
      position     = '0;
      body_pos     = '0;
      body_line_no = '0;
   endfunction

   function automatic void open_body(scan_mode_type next_mode);
      mode         = next_mode;
      body_pos     = position + 1;
      body_line_no = line_no;
      star_pending = 1'b0;
      multi_line   = 1'b0;
      escaped      = 1'b0;
   endfunction

   function automatic void plain_byte(logic [7:0] c);
      mode = MODE_NORMAL;
      if (c == CHAR_SLASH)
         mode = MODE_SLASH;
      else if (c == CHAR_SQUOTE)
         open_body(MODE_SQUOTE);
      else if (c == CHAR_DQUOTE)
         open_body(MODE_DQUOTE);
      else if (c == CHAR_NEWLINE)
         line_no = line_no + 1;
   endfunction

   function automatic void add_report(comment_kind_type kind, logic [OUT_BITS-1:0] last_pos);
      comment_report_type r;
      r.comment_kind = kind;
      r.start_offset = body_pos;
      r.end_offset   = last_pos;
      r.start_line   = body_line_no;
      expected_reports.push_back(r);
   endfunction

   // Advances the predicted scan by one source byte.
   function automatic void scan_text_byte(logic [7:0] c);
      logic [OUT_BITS-1:0] pos;
      pos = position;
      if (c == CHAR_END) begin
         if (mode == MODE_LINE || mode == MODE_BLOCK ||
             mode == MODE_SQUOTE || mode == MODE_DQUOTE)
            add_report(KIND_UNTERMINATED, pos - 1);
         clear_scan();
         return;
      end
      case (mode)
         MODE_SLASH: begin
            if (c == CHAR_SLASH)
               open_body(MODE_LINE);
            else if (c == CHAR_STAR)
               open_body(MODE_BLOCK);
            else
               plain_byte(c);
         end
         MODE_LINE: begin
            if (c == CHAR_NEWLINE) begin
               add_report(KIND_LINE, pos - 1);
               line_no = line_no + 1;
               mode    = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            if (c == CHAR_SLASH && star_pending) begin
               add_report(multi_line ? KIND_BLOCK_MULTI : KIND_BLOCK_ONE, pos - 2);
               mode         = MODE_NORMAL;
               star_pending = 1'b0;
               multi_line   = 1'b0;
            end else begin
               if (c == CHAR_NEWLINE) begin
                  line_no    = line_no + 1;
                  multi_line = 1'b1;
               end
               star_pending = (c == CHAR_STAR);
            end
         end
         MODE_SQUOTE, MODE_DQUOTE: begin
            if (c == CHAR_NEWLINE)
               line_no = line_no + 1;
            if (escaped)
               escaped = 1'b0;
            else if (c == CHAR_BACKSLASH)
               escaped = 1'b1;
            else if ((mode == MODE_SQUOTE && c == CHAR_SQUOTE) ||
                     (mode == MODE_DQUOTE && c == CHAR_DQUOTE))
               mode = MODE_NORMAL;
         end
         default: plain_byte(c);
      endcase
      position = pos + 1;
   endfunction

   // A report is registered before it leaves, so the report side is
   // handled before the byte of the same edge.
   always @(posedge clock) begin : watch
      comment_report_type want;
      comment_report_type got;
      if (reset) begin
         clear_scan();
         expected_reports.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.comment_kind = rsp_chan.comment_kind;
            got.start_offset = rsp_chan.start_offset;
            got.end_offset   = rsp_chan.end_offset;
            got.start_line   = rsp_chan.start_line;
            if (expected_reports.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected comment report: kind %0d start %0d end %0d line %0d",
                           $time, got.comment_kind, got.start_offset, got.end_offset,
                           got.start_line);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (got.comment_kind !== want.comment_kind ||
                   got.start_offset !== want.start_offset ||
                   got.end_offset !== want.end_offset ||
                   got.start_line !== want.start_line) begin
                  if (mismatches < 10) begin
                     $display("%0t: comment report mismatch", $time);
                     $display("   expected kind %0d start %0d end %0d line %0d",
                              want.comment_kind, want.start_offset, want.end_offset,
                              want.start_line);
                     $display("   actual   kind %0d start %0d end %0d line %0d",
                              got.comment_kind, got.start_offset, got.end_offset,
                              got.start_line);
                  end
                  mismatches++;
               end
               checked++;
            end
         end
         if (req_chan.valid && req_chan.ready)
            scan_text_byte(req_chan.text_byte);
      end
      error_count     <= mismatches;
      reports_pending <= expected_reports.size();
      reports_checked <= checked;
   end

endmodule

// File: bench/c_comment_extractor_test.sv
// Top of the C comment extractor testbench: clock, reset, source text and verdict.
module c_comment_extractor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cce_pkg::*;

   // Roughly 25 directed bytes followed by random fragments until at least this many bytes have gone in.
   localparam int TOTAL_ITEMS      = 1050;
   // From this byte count onwards neither side idles any more.
   localparam int CALM_AFTER       = 900;
   // The long stall of the result side starts once this many bytes have gone in.
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 48;
   // The block answers from its single result register; a few spare cycles are plenty.
   localparam int DRAIN_CYCLES     = 8;

   logic clock;
   logic reset;
   int   sent_count;
   int   error_count;
   int   reports_pending;
   int   reports_checked;

   cce_req_if req_chan ();
   cce_rsp_if rsp_chan ();

   c_comment_extractor u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   c_comment_extractor_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .error_count     (error_count),
      .reports_pending (reports_pending),
      .reports_checked (reports_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset is held from the start and then released for good.
   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Safety net: a correct run takes only a small fraction of this time.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // A byte that steers the scanner with a good chance, otherwise any non-zero byte.
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 9))
         0: return CHAR_SLASH;
         1: return CHAR_STAR;
         2: return CHAR_NEWLINE;
         3: return CHAR_SQUOTE;
         4: return CHAR_DQUOTE;
         5: return CHAR_BACKSLASH;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // Content of a comment or literal body: mostly plain bytes, with some newlines,
   // stars, slashes and backslashes so that the interesting corners get exercised.
   function automatic logic [7:0] body_byte();
      case ($urandom_range(0, 11))
         0: return CHAR_NEWLINE;
         1: return CHAR_STAR;
         2: return CHAR_SLASH;
         3: return CHAR_BACKSLASH;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // Offers one byte, with an occasional short gap first, and returns once the
   // transaction has taken place. Valid stays high between back-to-back bytes.
   task automatic send_text_byte(input logic [7:0] value);
      if (sent_count < CALM_AFTER && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.text_byte <= value;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sent_count++;
   endtask

   // Builds one random piece of C-like text and sends it. Most pieces are
   // well-formed comments and literals with random bodies; the rest is noise,
   // pieces cut short by the end of text, and bare end-of-text bytes.
   task automatic send_fragment();
      logic [7:0] text [$];
      int         pick;
      int         body_len;
      pick     = $urandom_range(0, 99);
      body_len = $urandom_range(0, 10);
      if (pick < 25) begin
         text.push_back(CHAR_SLASH);
         text.push_back(CHAR_SLASH);
         repeat (body_len) text.push_back(body_byte());
         text.push_back(CHAR_NEWLINE);
      end else if (pick < 50) begin
         text.push_back(CHAR_SLASH);
         text.push_back(CHAR_STAR);
         repeat (body_len) text.push_back(body_byte());
         text.push_back(CHAR_STAR);
         text.push_back(CHAR_SLASH);
      end else if (pick < 65) begin
         text.push_back(CHAR_DQUOTE);
         repeat (body_len) text.push_back(body_byte());
         text.push_back(CHAR_DQUOTE);
      end else if (pick < 73) begin
         text.push_back(CHAR_SQUOTE);
         if ($urandom_range(0, 1) == 1)
            text.push_back(CHAR_BACKSLASH);
         text.push_back(body_byte());
         text.push_back(CHAR_SQUOTE);
      end else if (pick < 93) begin
         repeat ($urandom_range(1, 6)) text.push_back(noise_byte());
      end else if (pick < 97) begin
         // An opener whose body is cut off by the end of text.
         case ($urandom_range(0, 3))
            0: begin
               text.push_back(CHAR_SLASH);
               text.push_back(CHAR_SLASH);
            end
            1: begin
               text.push_back(CHAR_SLASH);
               text.push_back(CHAR_STAR);
            end
            2: text.push_back(CHAR_DQUOTE);
            default: text.push_back(CHAR_SQUOTE);
         endcase
         repeat ($urandom_range(0, 4)) text.push_back(body_byte());
         text.push_back(CHAR_END);
      end else begin
         text.push_back(CHAR_END);
      end
      foreach (text[i]) send_text_byte(text[i]);
   endtask

   // Result side: short random stalls, one long stall that backs the block up
   // into its input, and a steady ready once the run has entered its calm tail.
   initial begin : result_taker
      int held;
      bit long_hold_done;
      long_hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clock);
         end else if (sent_count < CALM_AFTER && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Source side: a directed opening, then random text, then the drain and the verdict.
   initial begin : text_feeder
      logic [7:0] opening_text [$];
      req_chan.valid     <= 1'b0;
      req_chan.text_byte <= CHAR_END;
      sent_count = 0;
      // Empty line comment; empty block comment; a block whose opener is followed
      // by a slash and which spans two lines; a slash before a quote, so the quote
      // opens a string; an escaped newline inside that string; a stray backslash
      // and a byte of all ones in plain text; a character literal cut off by the
      // end of text; and a lone slash right before the end of text.
      opening_text = '{CHAR_SLASH, CHAR_SLASH, CHAR_NEWLINE,
                       CHAR_SLASH, CHAR_STAR, CHAR_STAR, CHAR_SLASH,
                       CHAR_SLASH, CHAR_STAR, CHAR_SLASH, CHAR_NEWLINE, CHAR_STAR, CHAR_SLASH,
                       CHAR_SLASH, CHAR_DQUOTE, CHAR_BACKSLASH, CHAR_NEWLINE, CHAR_DQUOTE,
                       CHAR_BACKSLASH, 8'hFF,
                       CHAR_SQUOTE, 8'h01, CHAR_END,
                       CHAR_SLASH, CHAR_END};
      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (opening_text[i]) send_text_byte(opening_text[i]);
      while (sent_count < TOTAL_ITEMS) send_fragment();
      req_chan.valid <= 1'b0;

      // The checker's pending count is registered, so step the clock before looking.
      do @(posedge clock); while (reports_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Scanned %0d source bytes: directed corners, random comments, literals,",
               sent_count);
      $display("noise and cut-off text, with gaps on both sides; %0d comment reports compared.",
               reports_checked);
      if (error_count == 0 && reports_pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
